// ----- src/ctfl_pkg.sv -----
// Shared constants, types and the CRC-8 byte step for the target frame link.
`timescale 1ns / 1ps

package ctfl_pkg;

  localparam logic [7:0]  HdrA      = 8'hA5;
  localparam logic [7:0]  HdrB      = 8'h5A;
  localparam logic [7:0]  CrcPoly   = 8'h31;
  localparam logic [7:0]  CrcInit   = 8'hFF;
  localparam logic [7:0]  CrcMsb    = 8'h80;

  // Byte positions inside the 12-byte frame.
  localparam logic [3:0]  PosHdrA   = 4'd0;
  localparam logic [3:0]  PosHdrB   = 4'd1;
  localparam logic [3:0]  PosMode   = 4'd2;
  localparam logic [3:0]  PosPitch0 = 4'd3;
  localparam logic [3:0]  PosPitch1 = 4'd4;
  localparam logic [3:0]  PosPitch2 = 4'd5;
  localparam logic [3:0]  PosPitch3 = 4'd6;
  localparam logic [3:0]  PosYaw0   = 4'd7;
  localparam logic [3:0]  PosYaw1   = 4'd8;
  localparam logic [3:0]  PosYaw2   = 4'd9;
  localparam logic [3:0]  PosYaw3   = 4'd10;
  localparam logic [3:0]  PosCrc    = 4'd11;
  localparam logic [3:0]  FrameLen  = 4'd12;

  // Configuration register indexes.
  localparam logic [1:0]  RegModeSetting    = 2'd0;
  localparam logic [1:0]  RegTargetTimeout  = 2'd1;
  localparam logic [1:0]  RegTransmitPeriod = 2'd2;

  localparam logic [31:0] TargetTimeoutRst  = 32'd100;
  localparam logic [31:0] TransmitPeriodRst = 32'd10;

  localparam logic        OpRxByte  = 1'b0;
  localparam logic        OpCycle   = 1'b1;
  localparam logic        KindStatus = 1'b0;
  localparam logic        KindFrame  = 1'b1;

  // Summary of the collected frame, as seen by the cycle logic.
  typedef struct packed {
    logic        pending;
    logic        valid;
    logic        mode_one;
    logic [31:0] pitch;
    logic [31:0] yaw;
  } rx_frame_t;

  // Transmit sequencer status.
  typedef struct packed {
    logic       active;
    logic [7:0] tx_byte;
    logic       last;
  } tx_stat_t;

  // One result item.
  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic        aim_valid;
    logic        track_ok;
    logic [31:0] target_pitch_bits;
    logic [31:0] target_yaw_bits;
    logic [31:0] frame_count;
  } out_item_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if ((c & CrcMsb) != 8'd0) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- src/ctfl_in_if.sv -----
// Input request channel: valid/ready handshake with the input item fields.
`timescale 1ns / 1ps

interface ctfl_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  rx_byte;
  logic        frame_start;
  logic [31:0] elapsed_ms;
  logic        imu_present;
  logic [31:0] imu_pitch_bits;
  logic [31:0] imu_yaw_bits;
  logic        link_busy;

  modport source (
    output valid, op, rx_byte, frame_start, elapsed_ms, imu_present,
           imu_pitch_bits, imu_yaw_bits, link_busy,
    input  ready
  );
  modport sink (
    input  valid, op, rx_byte, frame_start, elapsed_ms, imu_present,
           imu_pitch_bits, imu_yaw_bits, link_busy,
    output ready
  );
endinterface

// ----- src/ctfl_out_if.sv -----
// Result request channel: valid/ready handshake with the result item fields.
`timescale 1ns / 1ps

interface ctfl_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic        aim_valid;
  logic        track_ok;
  logic [31:0] target_pitch_bits;
  logic [31:0] target_yaw_bits;
  logic [31:0] frame_count;

  modport source (
    output valid, kind, tx_byte, last, aim_valid, track_ok,
           target_pitch_bits, target_yaw_bits, frame_count,
    input  ready
  );
  modport sink (
    input  valid, kind, tx_byte, last, aim_valid, track_ok,
           target_pitch_bits, target_yaw_bits, frame_count,
    output ready
  );
endinterface

// ----- src/ctfl_rx.sv -----
// Receive frame collector: byte store, position, pending flag and running CRC.
`timescale 1ns / 1ps

module ctfl_rx import ctfl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_we_i,
  input  logic [7:0] byte_i,
  input  logic       frame_start_i,
  input  logic       consume_i,
  output rx_frame_t  frame_o
);

  logic [7:0] store_q [FrameLen];
  logic [3:0] pos_q, pos_d, pos_eff;
  logic       pending_q, pending_d;
  logic [7:0] crc_q, crc_d;
  logic       in_range;

  assign pos_eff  = frame_start_i ? PosHdrA : pos_q;
  assign in_range = pos_eff < FrameLen;

  always_comb begin
    pos_d     = pos_q;
    pending_d = pending_q;
    crc_d     = crc_q;
    if (byte_we_i) begin
      if (frame_start_i) begin
        pending_d = 1'b0;
      end
      if (in_range) begin
        pos_d = pos_eff + 4'd1;
        if (pos_eff == PosCrc) begin
          pending_d = 1'b1;
        end
        // CRC covers bytes 0 to 10; restart it on the first byte
        if (pos_eff == PosHdrA) begin
          crc_d = crc8_step(CrcInit, byte_i);
        end else if (pos_eff < PosCrc) begin
          crc_d = crc8_step(crc_q, byte_i);
        end
      end
    end else if (consume_i) begin
      pending_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      pending_q <= 1'b0;
      crc_q     <= CrcInit;
    end else begin
      pos_q     <= pos_d;
      pending_q <= pending_d;
      crc_q     <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_we_i && in_range) begin
      store_q[pos_eff] <= byte_i;
    end
  end

  assign frame_o.pending  = pending_q;
  assign frame_o.valid    = (store_q[PosHdrA] == HdrA) && (store_q[PosHdrB] == HdrB) &&
                            (store_q[PosMode] <= 8'd1) && (store_q[PosCrc] == crc_q);
  assign frame_o.mode_one = store_q[PosMode] == 8'd1;
  assign frame_o.pitch    = {store_q[PosPitch3], store_q[PosPitch2],
                             store_q[PosPitch1], store_q[PosPitch0]};
  assign frame_o.yaw      = {store_q[PosYaw3], store_q[PosYaw2],
                             store_q[PosYaw1], store_q[PosYaw0]};

endmodule

// ----- src/ctfl_tx.sv -----
// Transmit sequencer: serializes one attitude frame, building its CRC per byte.
`timescale 1ns / 1ps

module ctfl_tx import ctfl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        mode_i,
  input  logic [31:0] pitch_i,
  input  logic [31:0] yaw_i,
  input  logic        advance_i,
  output tx_stat_t    stat_o
);

  logic        active_q, active_d;
  logic [3:0]  idx_q, idx_d;
  logic [7:0]  crc_q, crc_d;
  logic        mode_q;
  logic [31:0] pitch_q, yaw_q;
  logic [7:0]  raw_byte;
  logic        is_last;

  always_comb begin
    case (idx_q)
      PosHdrA:   raw_byte = HdrA;
      PosHdrB:   raw_byte = HdrB;
      PosMode:   raw_byte = {7'd0, mode_q};
      PosPitch0: raw_byte = pitch_q[7:0];
      PosPitch1: raw_byte = pitch_q[15:8];
      PosPitch2: raw_byte = pitch_q[23:16];
      PosPitch3: raw_byte = pitch_q[31:24];
      PosYaw0:   raw_byte = yaw_q[7:0];
      PosYaw1:   raw_byte = yaw_q[15:8];
      PosYaw2:   raw_byte = yaw_q[23:16];
      PosYaw3:   raw_byte = yaw_q[31:24];
      default:   raw_byte = crc_q;
    endcase
  end

  assign is_last = idx_q == PosCrc;

  always_comb begin
    active_d = active_q;
    idx_d    = idx_q;
    crc_d    = crc_q;
    if (start_i) begin
      active_d = 1'b1;
      idx_d    = PosHdrA;
      crc_d    = CrcInit;
    end else if (advance_i && active_q) begin
      crc_d = crc8_step(crc_q, raw_byte);
      idx_d = idx_q + 4'd1;
      if (is_last) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
      crc_q    <= CrcInit;
    end else begin
      active_q <= active_d;
      idx_q    <= idx_d;
      crc_q    <= crc_d;
    end
  end

  // latch the snapshot for the frame being sent
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mode_q  <= mode_i;
      pitch_q <= pitch_i;
      yaw_q   <= yaw_i;
    end
  end

  assign stat_o.active  = active_q;
  assign stat_o.tx_byte = raw_byte;
  assign stat_o.last    = is_last;

endmodule

// ----- src/crc8_target_frame_link_unit.sv -----
// Top level of the CRC-8 framed target link: timers, target hold and result register.
`timescale 1ns / 1ps

// Receive requests (op 0) produce no result and are taken one per cycle while no
// frame is being sent and the output register is free. A cycle request (op 1)
// yields a status result from the output register; when it also sends an attitude
// frame, the frame sequencer then emits the 12 frame bytes, one byte and one CRC-8
// step per cycle whenever the output register is free, and no new request is taken
// until the last byte has left the output register. Configuration writes take
// effect at the next clock edge.
module crc8_target_frame_link_unit import ctfl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ctfl_in_if.sink     in_chan_i,
  ctfl_out_if.source  out_chan_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  logic        mode_q;
  logic [31:0] timeout_q, period_q;
  logic [31:0] tgt_timer_q, tgt_timer_d;
  logic [31:0] tx_timer_q, tx_timer_d;
  logic [31:0] held_pitch_q, held_pitch_d;
  logic [31:0] held_yaw_q, held_yaw_d;
  logic        held_valid_q, held_valid_d;
  logic [31:0] count_q, count_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  logic        in_acc, rx_acc, cyc_acc, out_free, send, frame_load;
  logic [32:0] tgt_sum, tx_sum;
  logic [31:0] tgt_sat, tx_sat;
  rx_frame_t   rx_frame;
  tx_stat_t    tx_stat;

  assign out_free        = !out_valid_q || out_chan_o.ready;
  assign in_chan_i.ready = !tx_stat.active && out_free;
  assign in_acc          = in_chan_i.valid && in_chan_i.ready;
  assign rx_acc          = in_acc && (in_chan_i.op == OpRxByte);
  assign cyc_acc         = in_acc && (in_chan_i.op == OpCycle);
  assign frame_load      = tx_stat.active && out_free;

  ctfl_rx u_rx (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_we_i     (rx_acc),
    .byte_i        (in_chan_i.rx_byte),
    .frame_start_i (in_chan_i.frame_start),
    .consume_i     (cyc_acc),
    .frame_o       (rx_frame)
  );

  ctfl_tx u_tx (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cyc_acc && send),
    .mode_i    (mode_q),
    .pitch_i   (in_chan_i.imu_pitch_bits),
    .yaw_i     (in_chan_i.imu_yaw_bits),
    .advance_i (frame_load),
    .stat_o    (tx_stat)
  );

  // saturating timer adds
  assign tgt_sum = {1'b0, tgt_timer_q} + {1'b0, in_chan_i.elapsed_ms};
  assign tx_sum  = {1'b0, tx_timer_q} + {1'b0, in_chan_i.elapsed_ms};
  assign tgt_sat = tgt_sum[32] ? '1 : tgt_sum[31:0];
  assign tx_sat  = tx_sum[32] ? '1 : tx_sum[31:0];

  assign send = (tx_sat >= period_q) && in_chan_i.imu_present && !in_chan_i.link_busy;

  always_comb begin
    tgt_timer_d  = tgt_timer_q;
    tx_timer_d   = tx_timer_q;
    held_pitch_d = held_pitch_q;
    held_yaw_d   = held_yaw_q;
    held_valid_d = held_valid_q;
    count_d      = count_q;
    if (cyc_acc) begin
      tgt_timer_d = tgt_sat;
      tx_timer_d  = send ? '0 : tx_sat;
      if (rx_frame.pending && rx_frame.valid) begin
        held_pitch_d = rx_frame.pitch;
        held_yaw_d   = rx_frame.yaw;
        held_valid_d = rx_frame.mode_one;
        count_d      = count_q + 32'd1;
        tgt_timer_d  = '0;
      end
      if (tgt_timer_d > timeout_q) begin
        held_valid_d = 1'b0;
      end
    end
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (cyc_acc) begin
      out_d.kind              = KindStatus;
      out_d.tx_byte           = 8'd0;
      out_d.last              = !send;
      out_d.aim_valid         = held_valid_d;
      out_d.track_ok          = held_valid_d;
      out_d.target_pitch_bits = held_pitch_d;
      out_d.target_yaw_bits   = held_yaw_d;
      out_d.frame_count       = count_d;
      out_valid_d             = 1'b1;
    end else if (frame_load) begin
      out_d.kind              = KindFrame;
      out_d.tx_byte           = tx_stat.tx_byte;
      out_d.last              = tx_stat.last;
      out_d.aim_valid         = 1'b0;
      out_d.track_ok          = 1'b0;
      out_d.target_pitch_bits = '0;
      out_d.target_yaw_bits   = '0;
      out_d.frame_count       = '0;
      out_valid_d             = 1'b1;
    end else if (out_chan_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= 1'b0;
      timeout_q    <= TargetTimeoutRst;
      period_q     <= TransmitPeriodRst;
      tgt_timer_q  <= TargetTimeoutRst;
      tx_timer_q   <= '0;
      held_pitch_q <= '0;
      held_yaw_q   <= '0;
      held_valid_q <= 1'b0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegModeSetting:    mode_q    <= cfg_data_i[0];
          RegTargetTimeout:  timeout_q <= cfg_data_i;
          RegTransmitPeriod: period_q  <= cfg_data_i;
          default: ;
        endcase
      end
      tgt_timer_q  <= tgt_timer_d;
      tx_timer_q   <= tx_timer_d;
      held_pitch_q <= held_pitch_d;
      held_yaw_q   <= held_yaw_d;
      held_valid_q <= held_valid_d;
      count_q      <= count_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_chan_o.valid             = out_valid_q;
  assign out_chan_o.kind              = out_q.kind;
  assign out_chan_o.tx_byte           = out_q.tx_byte;
  assign out_chan_o.last              = out_q.last;
  assign out_chan_o.aim_valid         = out_q.aim_valid;
  assign out_chan_o.track_ok          = out_q.track_ok;
  assign out_chan_o.target_pitch_bits = out_q.target_pitch_bits;
  assign out_chan_o.target_yaw_bits   = out_q.target_yaw_bits;
  assign out_chan_o.frame_count       = out_q.frame_count;

endmodule
